// File: design/sspg_pkg.sv
package sspg_pkg;

   // Defaults for the top-level parameters
   localparam int COORD_BITS_DEFAULT = 12;
   localparam int FRAC_BITS_DEFAULT  = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCAN_MODE    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_ENABLE  = 2'd3;

   // Field widths
   localparam int MODE_W    = 2;
   localparam int SPEED_W   = 16;
   localparam int SPEED_FRAC = 8;
   localparam int POS_OUT_W = 20;

   localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;

   localparam logic CMD_ADVANCE = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic LOOP_RESET = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [SPEED_W-1:0] speed;
   } req_payload_type;

   typedef struct packed {
      logic [POS_OUT_W-1:0] pos_x;
      logic [POS_OUT_W-1:0] pos_y;
      logic                 done_res;
   } rsp_payload_type;

endpackage

// File: design/serpentine_scan_position_generator.sv
// Serpentine scan position generator.
// Request channel (req_valid / req_stall / req_payload): one beat is either an
// advance by an unsigned Q8.8 speed or a restart at the origin.
// Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one beat per
// request beat, carrying the updated x/y position in Q(COORD_BITS).(FRAC_BITS)
// and the done flag of a non-looping scan.
// The response is registered: it shows in the cycle after its request is accepted.
// Throughput is one beat per cycle while the receiver does not stall; the single position
// update (one add, compare and clamp) sits between the state registers and the response register.
// When the receiver stalls with a response held, req_stall goes high in the
// same cycle; the held response does not change. Once the response is taken,
// the next request is accepted in that same cycle.
// Configuration (csr_*) is to be written by the user while the block is idle; the block does
// not enforce this. Size writes, and mode writes that change the mode, restart the scan
// when both dimensions are nonzero. Reset (synchronous) clears the position, line,
// direction and done flag, zeros width, height and mode, sets loop_enable and empties the response.
module serpentine_scan_position_generator #(
   parameter int COORD_BITS = sspg_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = sspg_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  sspg_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output sspg_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [sspg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sspg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int P   = COORD_BITS + FRAC_BITS;   // position width
   localparam int P1  = P + 1;
   localparam int SW  = FRAC_BITS + sspg_pkg::SPEED_FRAC;   // scaled speed width
   localparam int AW  = ((P > SW) ? P : SW) + 1;  // sum width, no overflow
   localparam int DW  = COORD_BITS + 1;           // clamped dimension width
   localparam int WB  = (DW > sspg_pkg::CSR_DATA_W) ? DW : sspg_pkg::CSR_DATA_W;
   localparam int SHL = (FRAC_BITS >= sspg_pkg::SPEED_FRAC) ?
                        FRAC_BITS - sspg_pkg::SPEED_FRAC : 0;
   localparam int SHR = (FRAC_BITS >= sspg_pkg::SPEED_FRAC) ?
                        0 : sspg_pkg::SPEED_FRAC - FRAC_BITS;
   localparam int XW  = sspg_pkg::SPEED_W + 16;   // room for speed scaling

   localparam logic [WB-1:0] DIM_MAX  = WB'(64'd1 << COORD_BITS);
   localparam logic [P1-1:0] ONE_PIX  = P1'(64'd1 << FRAC_BITS);

   // Configuration registers
   logic [sspg_pkg::CSR_DATA_W-1:0] image_width_ff,  image_width_in;
   logic [sspg_pkg::CSR_DATA_W-1:0] image_height_ff, image_height_in;
   logic [sspg_pkg::MODE_W-1:0]     scan_mode_ff,    scan_mode_in;
   logic                            loop_enable_ff,  loop_enable_in;

   // Scan state
   logic [P-1:0]          x_ff, x_in;
   logic [P-1:0]          y_ff, y_in;
   logic [COORD_BITS-1:0] line_ff, line_in;
   logic                  rtl_ff, rtl_in;
   logic                  done_ff, done_in;

   // Response register
   logic                       rsp_valid_ff, rsp_valid_in;
   sspg_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic                  req_accept;
   logic                  ready;
   logic [WB-1:0]         w_ext, h_ext;
   logic [DW-1:0]         dim_w, dim_h;
   logic [COORD_BITS-1:0] dim_w_m1, dim_h_m1;
   logic [P-1:0]          edge_x, bottom_y;
   logic [P1-1:0]         full_w;
   logic [SW-1:0]         step;
   logic [AW-1:0]         x_aw, y_aw, s_aw, nx_aw, ny_aw;
   logic [P1-1:0]         vx;
   logic [DW-1:0]         next_line;
   logic                  hit_edge;
   logic [31:0]           x_wide, y_wide;

   // Accept a request whenever the response slot is free or draining
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign ready = (|image_width_ff) & (|image_height_ff);

   // Clamp oversized dimensions to 2^COORD_BITS
   assign w_ext = WB'(image_width_ff);
   assign h_ext = WB'(image_height_ff);
   assign dim_w = DW'((w_ext > DIM_MAX) ? DIM_MAX : w_ext);
   assign dim_h = DW'((h_ext > DIM_MAX) ? DIM_MAX : h_ext);
   assign dim_w_m1 = COORD_BITS'(dim_w - DW'(1));
   assign dim_h_m1 = COORD_BITS'(dim_h - DW'(1));

   assign edge_x   = P'(dim_w_m1) << FRAC_BITS;
   assign bottom_y = P'(dim_h_m1) << FRAC_BITS;
   assign full_w   = P1'(dim_w) << FRAC_BITS;

   // Rescale the Q8.8 speed to the position's fraction, truncating
   assign step = SW'((XW'(req_payload.speed) << SHL) >> SHR);

   assign x_aw  = AW'(x_ff);
   assign y_aw  = AW'(y_ff);
   assign s_aw  = AW'(step);
   assign nx_aw = x_aw + s_aw;
   assign ny_aw = y_aw + s_aw;
   assign vx    = P1'(x_ff) + ONE_PIX;
   assign next_line = DW'(line_ff) + DW'(1);

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      scan_mode_in    = scan_mode_ff;
      loop_enable_in  = loop_enable_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      line_in         = line_ff;
      rtl_in          = rtl_ff;
      done_in         = done_ff;
      hit_edge        = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            sspg_pkg::REG_IMAGE_WIDTH: begin
               image_width_in = csr_wdata;
               if ((|csr_wdata) && (|image_height_ff)) begin
                  x_in = '0; y_in = '0; line_in = '0; rtl_in = 1'b0; done_in = 1'b0;
               end
            end
            sspg_pkg::REG_IMAGE_HEIGHT: begin
               image_height_in = csr_wdata;
               if ((|csr_wdata) && (|image_width_ff)) begin
                  x_in = '0; y_in = '0; line_in = '0; rtl_in = 1'b0; done_in = 1'b0;
               end
            end
            sspg_pkg::REG_SCAN_MODE: begin
               if (csr_wdata[sspg_pkg::MODE_W-1:0] != scan_mode_ff) begin
                  scan_mode_in = csr_wdata[sspg_pkg::MODE_W-1:0];
                  if (ready) begin
                     x_in = '0; y_in = '0; line_in = '0; rtl_in = 1'b0; done_in = 1'b0;
                  end
               end
            end
            sspg_pkg::REG_LOOP_ENABLE: begin
               loop_enable_in = csr_wdata[0];
               if (csr_wdata[0]) begin
                  done_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (req_accept && ready) begin
         if (req_payload.cmd == sspg_pkg::CMD_RESTART) begin
            x_in = '0; y_in = '0; line_in = '0; rtl_in = 1'b0; done_in = 1'b0;
         end else if (!done_ff) begin
            if (scan_mode_ff == sspg_pkg::MODE_VERTICAL) begin
               // Advance down the column; at the bottom step one column over when looping, else stop there as done
               if (ny_aw >= AW'(bottom_y)) begin
                  if (loop_enable_ff) begin
                     y_in = '0;
                     x_in = (vx >= full_w) ? '0 : P'(vx);
                  end else begin
                     done_in = 1'b1;
                     y_in    = bottom_y;
                  end
               end else begin
                  y_in = P'(ny_aw);
               end
            end else begin
               // Move along the line and clamp at the edge
               if (rtl_ff) begin
                  if (s_aw >= x_aw) begin
                     x_in     = '0;
                     hit_edge = 1'b1;
                  end else begin
                     x_in = P'(x_aw - s_aw);
                  end
               end else begin
                  if (nx_aw >= AW'(edge_x)) begin
                     x_in     = edge_x;
                     hit_edge = 1'b1;
                  end else begin
                     x_in = P'(nx_aw);
                  end
               end
               if (hit_edge) begin
                  if (next_line >= dim_h) begin
                     if (loop_enable_ff) begin
                        x_in = '0; y_in = '0; line_in = '0; rtl_in = 1'b0; done_in = 1'b0;
                     end else begin
                        done_in = 1'b1;
                        line_in = dim_h_m1;
                        y_in    = bottom_y;
                     end
                  end else begin
                     // Drop to the next line and reverse direction
                     line_in = COORD_BITS'(next_line);
                     y_in    = P'(next_line) << FRAC_BITS;
                     rtl_in  = ~rtl_ff;
                     x_in    = rtl_ff ? '0 : edge_x;
                  end
               end
            end
         end
      end
   end

   // Response beat carries the updated state
   assign x_wide = 32'(x_in);
   assign y_wide = 32'(y_in);

   always_comb begin
      rsp_payload_in          = rsp_payload_ff;
      rsp_valid_in            = rsp_valid_ff & rsp_stall;
      if (req_accept) begin
         rsp_valid_in            = 1'b1;
         rsp_payload_in.pos_x    = x_wide[sspg_pkg::POS_OUT_W-1:0];
         rsp_payload_in.pos_y    = y_wide[sspg_pkg::POS_OUT_W-1:0];
         rsp_payload_in.done_res = done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= '0;
         image_height_ff <= '0;
         scan_mode_ff    <= sspg_pkg::MODE_HORIZONTAL;
         loop_enable_ff  <= sspg_pkg::LOOP_RESET;
         x_ff            <= '0;
         y_ff            <= '0;
         line_ff         <= '0;
         rtl_ff          <= 1'b0;
         done_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         scan_mode_ff    <= scan_mode_in;
         loop_enable_ff  <= loop_enable_in;
         x_ff            <= x_in;
         y_ff            <= y_in;
         line_ff         <= line_in;
         rtl_ff          <= rtl_in;
         done_ff         <= done_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // Done can only stand while looping is off
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !loop_enable_ff)
      else $error("scan done while loop enabled");

   // The line index stays inside the image while it is configured
   assert property (@(posedge clock) disable iff (reset) ready |-> (DW'(line_ff) < dim_h))
      else $error("line index beyond image height");

   // Every accepted request beat yields a response beat on the next cycle
   assert property (@(posedge clock) disable iff (reset) req_accept |=> rsp_valid_ff)
      else $error("accepted request without response");
`endif

endmodule
